// File: src/volume_axis_projection_top_assert.svh
// Assertion macros for the volume axis projection block.
`ifndef VOLUME_AXIS_PROJECTION_TOP_ASSERT_SVH
`define VOLUME_AXIS_PROJECTION_TOP_ASSERT_SVH

// clocked check, muted while reset is asserted
`define VAP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("vap check failed");

// clocked check that also holds during reset
`define VAP_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("vap check failed");

`endif

// File: src/vap_pkg.sv
// Shared constants for the volume axis projection block.
`default_nettype none
package vap_pkg;
	localparam int SIZE_W      = 13;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 10;

	localparam int MAX_SIZE_DEF    = 512;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int AIR_FLOOR       = -500;

	localparam logic [CFG_IDX_W-1:0] REG_AXIS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUB_EN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RSTART    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REND      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd7;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	localparam logic       MODE_MEAN = 1'b0;
	localparam logic       MODE_MAX  = 1'b1;

	localparam logic [9:0] REND_RST = 10'd512;
	localparam logic [9:0] SIZE_RST = 10'd512;
endpackage
`default_nettype wire

// File: src/vap_ifs.sv
// Stream interfaces: voxel input and pixel output.
`default_nettype none
interface vap_vox_if #(parameter int W = vap_pkg::SAMPLE_BITS_DEF);
	logic         valid;
	logic         ready;
	logic [W-1:0] voxel;
	modport source (output valid, output voxel, input ready);
	modport sink   (input valid, input voxel, output ready);
endinterface

interface vap_pix_if #(parameter int W = vap_pkg::SAMPLE_BITS_DEF);
	logic         valid;
	logic         ready;
	logic [W-1:0] pixel;
	logic         last_pixel;
	logic         range_error;
	modport source (output valid, output pixel, output last_pixel, output range_error,
		input ready);
	modport sink   (input valid, input pixel, input last_pixel, input range_error,
		output ready);
endinterface
`default_nettype wire

// File: src/vap_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module vap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: src/volume_axis_projection_top.sv
// Top level of the volume axis projection block.
// Usage:
//  vox_in  : voxel words in raster order (x fastest, then y, then z),
//            valid/ready, a word moves when both are high.
//  pix_out : projected pixel words with last_pixel and range_error flags.
//  cfg_*   : write port; write only while no word is in flight.
// Input hold: a voxel inside the counted slice range holds the input through
//  accept, address, read and modify/write of the single-port ray RAM; a voxel
//  outside the range is taken without leaving idle. A finished mean pixel then
//  runs the bit-serial divider before output staging; a max pixel goes straight
//  from modify/write to output staging; an empty-range pixel goes from accept
//  straight to output staging.
// Reset: counters, config, control and output valid clear; datapath registers
//  and accumulator RAM are not cleared, each ray restarts at its first counted slice.
// Stall: the pixel word holds in the output register; the block keeps
//  working and only waits if a second pixel is ready before the first goes.
`default_nettype none
module volume_axis_projection_top #(
	parameter int MAX_SIZE_X  = vap_pkg::MAX_SIZE_DEF,
	parameter int MAX_SIZE_Y  = vap_pkg::MAX_SIZE_DEF,
	parameter int MAX_SIZE_Z  = vap_pkg::MAX_SIZE_DEF,
	parameter int SAMPLE_BITS = vap_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	vap_vox_if.sink                                vox_in,
	vap_pix_if.source                              pix_out,
	input  wire logic                              cfg_we,
	input  wire logic [vap_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [vap_pkg::CFG_DATA_W-1:0]    cfg_data
);
	localparam int SW    = vap_pkg::SIZE_W;
	localparam int SB    = SAMPLE_BITS;
	localparam int MAXA  = (MAX_SIZE_X > MAX_SIZE_Y) ?
		((MAX_SIZE_X > MAX_SIZE_Z) ? MAX_SIZE_X : MAX_SIZE_Z) :
		((MAX_SIZE_Y > MAX_SIZE_Z) ? MAX_SIZE_Y : MAX_SIZE_Z);
	localparam int ACC_W = SB + $clog2(MAXA);
	localparam int CXW   = $clog2(MAX_SIZE_X);
	localparam int CYW   = $clog2(MAX_SIZE_Y);
	localparam int CZW   = $clog2(MAX_SIZE_Z);
	localparam int DEPTH = MAX_SIZE_X * MAX_SIZE_Y;
	localparam int AW    = $clog2(DEPTH);
	localparam int DCW   = $clog2(ACC_W + 1);
	localparam logic signed [32:0] AIR33 = 33'(vap_pkg::AIR_FLOOR);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ADDR = 3'd1;
	localparam logic [2:0] ST_READ = 3'd2;
	localparam logic [2:0] ST_MOD  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	// configuration
	logic [1:0] axis_q;
	logic       mode_q, sub_en_q;
	logic [8:0] rstart_q;
	logic [9:0] rend_q, size_x_q, size_y_q, size_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q   <= vap_pkg::AXIS_X;
			mode_q   <= vap_pkg::MODE_MEAN;
			sub_en_q <= 1'b0;
			rstart_q <= '0;
			rend_q   <= vap_pkg::REND_RST;
			size_x_q <= vap_pkg::SIZE_RST;
			size_y_q <= vap_pkg::SIZE_RST;
			size_z_q <= vap_pkg::SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vap_pkg::REG_AXIS:   axis_q   <= cfg_data[1:0];
				vap_pkg::REG_MODE:   mode_q   <= cfg_data[0];
				vap_pkg::REG_SUB_EN: sub_en_q <= cfg_data[0];
				vap_pkg::REG_RSTART: rstart_q <= cfg_data[8:0];
				vap_pkg::REG_REND:   rend_q   <= cfg_data;
				vap_pkg::REG_SIZE_X: size_x_q <= cfg_data;
				vap_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
				vap_pkg::REG_SIZE_Z: size_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective sizes: zero acts as one, clamp to the max
	logic [SW-1:0] sx, sy, sz;
	always_comb begin
		sx = (size_x_q == '0) ? SW'(1) :
			((SW'(size_x_q) > SW'(MAX_SIZE_X)) ? SW'(MAX_SIZE_X) : SW'(size_x_q));
		sy = (size_y_q == '0) ? SW'(1) :
			((SW'(size_y_q) > SW'(MAX_SIZE_Y)) ? SW'(MAX_SIZE_Y) : SW'(size_y_q));
		sz = (size_z_q == '0) ? SW'(1) :
			((SW'(size_z_q) > SW'(MAX_SIZE_Z)) ? SW'(MAX_SIZE_Z) : SW'(size_z_q));
	end

	logic [2:0]     state_q;
	logic [CXW-1:0] col_q;
	logic [CYW-1:0] row_q;
	logic [CZW-1:0] slc_q;

	wire accept = vox_in.valid && (state_q == ST_IDLE);
	assign vox_in.ready = (state_q == ST_IDLE);

	// raster position of this word, counters wrapped to current sizes
	logic [SW-1:0] cw, rw, zw, asize, coord, end_c, start_c, col_n, row_n, slc_n;
	logic [1:0]    ax;
	logic          last_c, empty_c, inr_c;
	always_comb begin
		cw = (SW'(col_q) >= sx) ? '0 : SW'(col_q);
		rw = (SW'(row_q) >= sy) ? '0 : SW'(row_q);
		zw = (SW'(slc_q) >= sz) ? '0 : SW'(slc_q);
		ax = (axis_q == vap_pkg::AXIS_X) ? vap_pkg::AXIS_X :
			((axis_q == vap_pkg::AXIS_Y) ? vap_pkg::AXIS_Y : vap_pkg::AXIS_Z);
		case (ax)
			vap_pkg::AXIS_X: begin
				asize  = sx;
				coord  = cw;
				last_c = (rw == sy - SW'(1)) && (zw == sz - SW'(1));
			end
			vap_pkg::AXIS_Y: begin
				asize  = sy;
				coord  = rw;
				last_c = (cw == sx - SW'(1)) && (zw == sz - SW'(1));
			end
			default: begin
				asize  = sz;
				coord  = zw;
				last_c = (cw == sx - SW'(1)) && (rw == sy - SW'(1));
			end
		endcase
		if (sub_en_q) begin
			start_c = SW'(rstart_q);
			end_c   = (SW'(rend_q) < asize) ? SW'(rend_q) : asize;
		end else begin
			start_c = '0;
			end_c   = asize;
		end
		empty_c = (end_c <= start_c);
		inr_c   = (coord >= start_c) && (coord < end_c);
		// advance
		col_n = cw + SW'(1);
		row_n = rw;
		slc_n = zw;
		if (col_n >= sx) begin
			col_n = '0;
			row_n = rw + SW'(1);
			if (row_n >= sy) begin
				row_n = '0;
				slc_n = zw + SW'(1);
				if (slc_n >= sz) begin
					slc_n = '0;
				end
			end
		end
	end

	// air clamp
	logic [SB-1:0]    vox;
	logic [32:0]      vwide;
	logic [ACC_W-1:0] term_c;
	always_comb begin
		vox   = vox_in.voxel;
		vwide = {{(33-SB){vox[SB-1]}}, vox};
		if (!mode_q && ($signed(vwide) < AIR33)) begin
			term_c = ACC_W'(AIR33);
		end else begin
			term_c = {{(ACC_W-SB){vox[SB-1]}}, vox};
		end
	end

	// per-word working registers
	logic [ACC_W-1:0] term_q;
	logic             first_q, final_q, mode_w_q, last_q;
	logic [1:0]       ax_q;
	logic [SW-1:0]    len_q, colw_q, roww_q, sxw_q;
	logic [AW-1:0]    addr_q;

	// RAM
	logic [ACC_W-1:0] rd, acc_c;
	vap_ram #(.WIDTH(ACC_W), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (state_q == ST_MOD),
		.addr  (addr_q),
		.wdata (acc_c),
		.rdata (rd)
	);

	always_comb begin
		if (first_q) begin
			acc_c = term_q;
		end else if (mode_w_q) begin
			acc_c = ($signed(term_q) > $signed(rd)) ? term_q : rd;
		end else begin
			acc_c = rd + term_q;
		end
	end

	// bit-serial divider and result hold
	logic [ACC_W-1:0] quo_q;
	logic [SW:0]      rem_q, rem_sh;
	logic             neg_q, step_bit;
	logic [DCW-1:0]   dcnt_q;
	logic [SB-1:0]    res_pix_q;
	logic             res_last_q, res_err_q;

	always_comb begin
		rem_sh   = {rem_q[SW-1:0], quo_q[ACC_W-1]};
		step_bit = (rem_sh >= {1'b0, len_q});
	end

	wire [ACC_W-1:0] qs = neg_q ? (~quo_q + ACC_W'(1)) : quo_q;
	wire [2*SW-1:0]  prod = roww_q * sxw_q;

	logic          out_valid_q;
	logic [SB-1:0] out_pix_q;
	logic          out_last_q, out_err_q;
	wire           out_free = !out_valid_q || pix_out.ready;

	// mean pixel takes the signed quotient; max and empty-range take the held value
	wire [SB-1:0] pix_sel = (!mode_w_q && !res_err_q) ? qs[SB-1:0] : res_pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			slc_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						col_q <= CXW'(col_n);
						row_q <= CYW'(row_n);
						slc_q <= CZW'(slc_n);
						if (empty_c) begin
							if (coord == '0) begin
								state_q <= ST_OUT;
							end
						end else if (inr_c) begin
							state_q <= ST_ADDR;
						end
					end
				end
				ST_ADDR: state_q <= ST_READ;
				ST_READ: state_q <= ST_MOD;
				ST_MOD: begin
					if (!final_q) begin
						state_q <= ST_IDLE;
					end else if (mode_w_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dcnt_q == DCW'(1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output word valid: set on staging, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				term_q   <= term_c;
				first_q  <= (coord == start_c);
				final_q  <= (coord == end_c - SW'(1));
				mode_w_q <= mode_q;
				last_q   <= last_c;
				ax_q     <= ax;
				len_q    <= end_c - start_c;
				colw_q   <= cw;
				roww_q   <= rw;
				sxw_q    <= sx;
				res_pix_q  <= mode_q ? {1'b1, {(SB-1){1'b0}}} : '0;
				res_last_q <= last_c;
				res_err_q  <= 1'b1;
			end
			ST_ADDR: begin
				case (ax_q)
					vap_pkg::AXIS_X: addr_q <= '0;
					vap_pkg::AXIS_Y: addr_q <= AW'(colw_q);
					default:         addr_q <= AW'(prod + (2*SW)'(colw_q));
				endcase
			end
			ST_MOD: begin
				res_last_q <= last_q;
				res_err_q  <= 1'b0;
				res_pix_q  <= acc_c[SB-1:0];
				neg_q      <= acc_c[ACC_W-1];
				quo_q      <= acc_c[ACC_W-1] ? (~acc_c + ACC_W'(1)) : acc_c;
				rem_q      <= '0;
				dcnt_q     <= DCW'(ACC_W);
			end
			ST_DIV: begin
				rem_q  <= step_bit ? (rem_sh - {1'b0, len_q}) : rem_sh;
				quo_q  <= {quo_q[ACC_W-2:0], step_bit};
				dcnt_q <= dcnt_q - DCW'(1);
			end
			ST_OUT: begin
				if (out_free) begin
					out_pix_q  <= pix_sel;
					out_last_q <= res_last_q;
					out_err_q  <= res_err_q;
				end
			end
			default: ;
		endcase
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.pixel       = out_pix_q;
	assign pix_out.last_pixel  = out_last_q;
	assign pix_out.range_error = out_err_q;
endmodule
`default_nettype wire

// File: src/vap_checker.sv
// Port-level checks for the volume axis projection block, with bind.
`default_nettype none
`include "volume_axis_projection_top_assert.svh"
module vap_checker #(
	parameter int W = vap_pkg::SAMPLE_BITS_DEF
) (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         in_valid,
	input wire logic         in_ready,
	input wire logic         out_valid,
	input wire logic         out_ready,
	input wire logic [W-1:0] pixel
);
	// input is held off in the cycle a pixel word is staged
	`VAP_ASSERT(a_stage_blocks_in, clk, arst_n, $rose(out_valid) |-> $past(!in_ready))
	// no pixel word while held in reset
	`VAP_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !out_valid)
	// a word can not show up in the cycle after an accept
	`VAP_ASSERT(a_no_early_pix, clk, arst_n,
		(in_valid && in_ready && !out_valid) |=> !out_valid)
	// stalled pixel holds
	`VAP_ASSERT(a_pix_hold, clk, arst_n,
		(out_valid && !out_ready) |=> (out_valid && $stable(pixel)))
endmodule

bind volume_axis_projection_top vap_checker #(.W(SAMPLE_BITS)) u_vap_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vox_in.valid),
	.in_ready  (vox_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.pixel     (pix_out.pixel)
);
`default_nettype wire

// File: dv/volume_axis_projection_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the volume axis projection block: small volumes, all axes and modes.
`default_nettype none
module volume_axis_projection_top_tb;

	localparam int MAX_SZ      = vap_pkg::MAX_SIZE_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 64;    // idle margin after the last expected pixel word
	localparam int RANDOM_WORDS = 340;
	localparam int CLAMP_WORDS  = 48;

	typedef struct packed {
		logic [15:0] pixel;
		logic        last_pixel;
		logic        range_error;
	} pixel_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [vap_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [vap_pkg::CFG_DATA_W-1:0] cfg_data;

	vap_vox_if vox ();
	vap_pix_if pix ();

	volume_axis_projection_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.vox_in(vox),
		.pix_out(pix),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// register mirror, same reset values as the block
	logic [1:0] m_axis;
	logic       m_mode;
	logic       m_sub_en;
	logic [8:0] m_rstart;
	logic [9:0] m_rend;
	logic [9:0] m_size_x, m_size_y, m_size_z;

	// raster position and per-ray accumulators of the projection model
	int unsigned col_pos, row_pos, slice_pos;
	longint ray_acc [int];

	pixel_word_t expected_pixels [$];
	int mismatches;
	int words_sent;
	int cycles = 0;
	int send_idle_pct;
	int sink_stall_pct;

	// clock; the one-time reset is applied in the main initial block
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// sink side: random back-pressure, changed on the falling edge
	always @(negedge clk)
		pix.ready <= ($urandom_range(99) >= sink_stall_pct);

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** volume_axis_projection_top: FAILED **");
			$finish;
		end
	end

	// output checker: every accepted pixel word against the oldest expectation
	always @(posedge clk) begin
		pixel_word_t exp_w;
		if (arst_n && pix.valid && pix.ready) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel word %h last %b err %b",
						pix.pixel, pix.last_pixel, pix.range_error);
			end else begin
				exp_w = expected_pixels.pop_front();
				if (pix.pixel !== exp_w.pixel || pix.last_pixel !== exp_w.last_pixel ||
					pix.range_error !== exp_w.range_error) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel mismatch: exp %0d/%b/%b got %0d/%b/%b",
							$signed(exp_w.pixel), exp_w.last_pixel, exp_w.range_error,
							$signed(pix.pixel), pix.last_pixel, pix.range_error);
				end
			end
		end
	end

	function automatic int unsigned eff_extent(logic [9:0] s);
		if (s == 0) return 1;
		return (s > MAX_SZ) ? MAX_SZ : s;
	endfunction

	// projection model: one accepted voxel, at most one pixel word expected
	function automatic void project_voxel(logic signed [15:0] v);
		int unsigned sx, sy, sz, asize, coord, lo, hi, ray;
		logic ends_image;
		longint term, acc;
		pixel_word_t w;
		sx = eff_extent(m_size_x);
		sy = eff_extent(m_size_y);
		sz = eff_extent(m_size_z);
		if (col_pos >= sx) col_pos = 0;
		if (row_pos >= sy) row_pos = 0;
		if (slice_pos >= sz) slice_pos = 0;
		if (m_axis == vap_pkg::AXIS_X) begin
			asize = sx; coord = col_pos; ray = 0;
			ends_image = (row_pos == sy - 1) && (slice_pos == sz - 1);
		end else if (m_axis == vap_pkg::AXIS_Y) begin
			asize = sy; coord = row_pos; ray = col_pos;
			ends_image = (col_pos == sx - 1) && (slice_pos == sz - 1);
		end else begin
			// selector three projects along z as well
			asize = sz; coord = slice_pos; ray = row_pos * sx + col_pos;
			ends_image = (col_pos == sx - 1) && (row_pos == sy - 1);
		end
		if (m_sub_en) begin
			lo = m_rstart;
			hi = (m_rend < asize) ? m_rend : asize;
		end else begin
			lo = 0;
			hi = asize;
		end
		if (hi <= lo) begin
			// empty range: flagged word at the ray's first voxel
			if (coord == 0) begin
				w.pixel = (m_mode == vap_pkg::MODE_MAX) ? 16'h8000 : 16'h0000;
				w.last_pixel = ends_image;
				w.range_error = 1'b1;
				expected_pixels.push_back(w);
			end
		end else if (coord >= lo && coord < hi) begin
			if (m_mode == vap_pkg::MODE_MAX) term = v;
			else term = (v < vap_pkg::AIR_FLOOR) ? vap_pkg::AIR_FLOOR : v;
			if (coord == lo) acc = term;
			else if (m_mode == vap_pkg::MODE_MAX)
				acc = (term > ray_acc[ray]) ? term : ray_acc[ray];
			else acc = ray_acc[ray] + term;
			ray_acc[ray] = acc;
			if (coord == hi - 1) begin
				if (m_mode == vap_pkg::MODE_MEAN) acc = acc / longint'(hi - lo);
				w.pixel = acc[15:0];
				w.last_pixel = ends_image;
				w.range_error = 1'b0;
				expected_pixels.push_back(w);
			end
		end
		col_pos++;
		if (col_pos >= sx) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= sy) begin
				row_pos = 0;
				slice_pos++;
				if (slice_pos >= sz) slice_pos = 0;
			end
		end
	endfunction

	// entered and left at a falling edge; valid stays high for back-to-back words
	task automatic send_voxel(logic [15:0] v);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			vox.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		vox.valid <= 1'b1;
		vox.voxel <= v;
		do @(posedge clk); while (!vox.ready);
		project_voxel(v);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		vox.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// raises the write enable; the caller drops it after the last write
	task automatic write_reg(logic [vap_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[vap_pkg::CFG_DATA_W-1:0];
		case (idx)
			vap_pkg::REG_AXIS:   m_axis = val[1:0];
			vap_pkg::REG_MODE:   m_mode = val[0];
			vap_pkg::REG_SUB_EN: m_sub_en = val[0];
			vap_pkg::REG_RSTART: m_rstart = val[8:0];
			vap_pkg::REG_REND:   m_rend = val[9:0];
			vap_pkg::REG_SIZE_X: m_size_x = val[9:0];
			vap_pkg::REG_SIZE_Y: m_size_y = val[9:0];
			vap_pkg::REG_SIZE_Z: m_size_z = val[9:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// whole setting at once, only with the block idle
	task automatic set_projection(int unsigned ax, int unsigned md, int unsigned sub,
		int unsigned rs, int unsigned re, int unsigned sx, int unsigned sy, int unsigned sz);
		wait_idle();
		write_reg(vap_pkg::REG_AXIS, ax);
		write_reg(vap_pkg::REG_MODE, md);
		write_reg(vap_pkg::REG_SUB_EN, sub);
		write_reg(vap_pkg::REG_RSTART, rs);
		write_reg(vap_pkg::REG_REND, re);
		write_reg(vap_pkg::REG_SIZE_X, sx);
		write_reg(vap_pkg::REG_SIZE_Y, sy);
		write_reg(vap_pkg::REG_SIZE_Z, sz);
		cfg_we <= 1'b0;
	endtask

	// one full volume; corner values mixed in when asked
	task automatic send_volume(bit corners);
		int unsigned n;
		logic [15:0] v;
		n = eff_extent(m_size_x) * eff_extent(m_size_y) * eff_extent(m_size_z);
		repeat (n) begin
			v = 16'($urandom);
			if (corners)
				case ($urandom_range(4))
					0: v = 16'h8000;
					1: v = 16'h7fff;
					2: v = -16'sd500;
					3: v = -16'sd501;
					default: ;
				endcase
			send_voxel(v);
		end
	endtask

	task automatic test_extreme_values();
		// mean along z and max along x, each on a 2x2x2 volume with corner samples mixed in
		set_projection(vap_pkg::AXIS_Z, vap_pkg::MODE_MEAN, 0, 0, vap_pkg::REND_RST, 2, 2, 2);
		send_volume(1);
		set_projection(vap_pkg::AXIS_X, vap_pkg::MODE_MAX, 0, 0, vap_pkg::REND_RST, 2, 2, 2);
		send_volume(1);
	endtask

	task automatic test_subrange_and_empty();
		// middle slice only, then an empty range in both modes
		set_projection(vap_pkg::AXIS_Y, vap_pkg::MODE_MEAN, 1, 1, 2, 1, 3, 2);
		send_volume(1);
		set_projection(vap_pkg::AXIS_Z, vap_pkg::MODE_MAX, 1, 511, 1023, 1, 1, 2);
		send_volume(0);
		set_projection(vap_pkg::AXIS_X, vap_pkg::MODE_MEAN, 1, 2, 1, 3, 1, 1);
		send_volume(0);
	endtask

	task automatic test_selector_and_size_clamp();
		// selector three acts as z; size 0 acts as 1; oversize x saturates,
		// every voxel of the first row is its own single-slice ray
		set_projection(3, vap_pkg::MODE_MAX, 0, 0, 0, 0, 2, 2);
		send_volume(1);
		set_projection(vap_pkg::AXIS_Y, vap_pkg::MODE_MEAN, 0, 0, vap_pkg::REND_RST,
			1023, 0, 0);
		repeat (CLAMP_WORDS) send_voxel(16'($urandom));
	endtask

	task automatic test_random_volumes();
		int phase;
		phase = 0;
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin send_idle_pct = 80; sink_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  sink_stall_pct = 80; end
				default: begin send_idle_pct = 33; sink_stall_pct = 33; end
			endcase
			set_projection($urandom_range(3), $urandom_range(1), $urandom_range(1),
				$urandom_range(6), $urandom_range(7), $urandom_range(5),
				$urandom_range(5), $urandom_range(5));
			send_volume($urandom_range(3) == 0);
			phase++;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		vox.valid = 1'b0;
		vox.voxel = '0;
		words_sent = 0;
		send_idle_pct = 0;
		sink_stall_pct = 0;
		m_axis = vap_pkg::AXIS_X;
		m_mode = vap_pkg::MODE_MEAN;
		m_sub_en = 1'b0;
		m_rstart = '0;
		m_rend = vap_pkg::REND_RST;
		m_size_x = vap_pkg::SIZE_RST;
		m_size_y = vap_pkg::SIZE_RST;
		m_size_z = vap_pkg::SIZE_RST;
		col_pos = 0;
		row_pos = 0;
		slice_pos = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extreme_values();
		test_subrange_and_empty();
		test_selector_and_size_clamp();
		test_random_volumes();

		wait_idle();
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("** volume_axis_projection_top: PASSED **");
		else
			$display("** volume_axis_projection_top: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
